>>> hdl/vdps_pkg.sv
package vdps_pkg;

    localparam int QW = 32;
    localparam int DTW = 25;
    localparam logic [DTW-1:0] DT_ONE = 25'd16777216;
    localparam logic signed [31:0] GRAV_Y_RST = -32'sd164573184;

    localparam logic [1:0] REG_GRAV_X = 2'd0;
    localparam logic [1:0] REG_GRAV_Y = 2'd1;
    localparam logic [1:0] REG_GRAV_Z = 2'd2;
    localparam logic [1:0] REG_DRAG   = 2'd3;

    // per-item payload carried down the pipe
    typedef struct packed {
        logic [2:0][QW-1:0] npos;
        logic [2:0][QW-1:0] nacc;
        logic [2:0][QW-1:0] vel;
        logic [2:0][QW-1:0] acc;
        logic [2:0][QW-1:0] absv;
        logic [DTW-1:0]     dt;
    } t_carry;

    function automatic logic [QW-1:0] sat32(input logic signed [63:0] v);
        logic [QW-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/verlet_drag_particle_step.sv
// One velocity Verlet step per particle with gravity and quadratic drag, all
// values signed Q8.24 with saturated results. A particle can enter every cycle
// while the skid register is empty. The speed magnitude comes from a 32-stage
// square root (one result bit per stage) with multiply stages around it. An
// output skid register lets the pipe keep taking items while one result waits.
// Registers may be written only while idle.
module verlet_drag_particle_step
    import vdps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x,pos_y,pos_z,vel_x,vel_y,vel_z,acc_x,acc_y,acc_z,time_step, zero pad
    input  logic [319:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // new_pos_x/y/z, new_vel_x/y/z, new_acc_x/y/z
    output logic [287:0] o_m_tdata
);

    localparam int NSQ = 32;

    logic signed [31:0] r_grav [3];
    logic [30:0]        r_drag_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0] <= '0;
            r_grav[1] <= GRAV_Y_RST;
            r_grav[2] <= '0;
            r_drag_k  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRAV_X: r_grav[0] <= i_cfg_data;
                REG_GRAV_Y: r_grav[1] <= i_cfg_data;
                REG_GRAV_Z: r_grav[2] <= i_cfg_data;
                REG_DRAG:   r_drag_k  <= i_cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    logic en;
    logic r_skid_valid;
    assign en = !r_skid_valid;
    assign o_s_tready = en;

    // ---------------- stage 1: unpack, clamp dt, |v|
    logic   r_v1;
    t_carry r_c1;
    t_carry n_c1;
    logic [2:0][31:0] r_pos1;
    always_comb begin
        logic [DTW-1:0] dti;
        n_c1 = '0;
        for (int i = 0; i < 3; i++) begin
            n_c1.vel[i]  = i_s_tdata[32*(3+i) +: 32];
            n_c1.acc[i]  = i_s_tdata[32*(6+i) +: 32];
            n_c1.absv[i] = i_s_tdata[32*(3+i)+31] ? (32'd0 - i_s_tdata[32*(3+i) +: 32])
                                                  : i_s_tdata[32*(3+i) +: 32];
        end
        dti = i_s_tdata[288 +: DTW];
        n_c1.dt = (dti > DT_ONE) ? DT_ONE : dti;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en)  r_v1 <= i_s_tvalid;
        if (en) begin
            r_c1 <= n_c1;
            for (int i = 0; i < 3; i++) r_pos1[i] <= i_s_tdata[32*i +: 32];
        end
    end

    // ---------------- stage 2: squares, dt^2
    logic   r_v2;
    t_carry r_c2;
    logic [2:0][31:0] r_pos2;
    logic [63:0] r_sq2 [3];
    logic [49:0] r_dd2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en)  r_v2 <= r_v1;
        if (en) begin
            r_c2   <= r_c1;
            r_pos2 <= r_pos1;
            for (int i = 0; i < 3; i++) r_sq2[i] <= r_c1.absv[i] * r_c1.absv[i];
            r_dd2 <= r_c1.dt * r_c1.dt;
        end
    end

    // ---------------- stage 3: |v|^2 sum, dt^2/2, vel*dt
    logic   r_v3;
    t_carry r_c3;
    logic [2:0][31:0] r_pos3;
    logic [63:0] r_x3;
    logic [23:0] r_hd2;
    logic signed [56:0] r_vdt3 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en)  r_v3 <= r_v2;
        if (en) begin
            r_c3   <= r_c2;
            r_pos3 <= r_pos2;
            r_x3   <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_hd2  <= r_dd2[48:25];
            for (int i = 0; i < 3; i++)
                r_vdt3[i] <= $signed(r_c2.vel[i]) * $signed({1'b0, r_c2.dt});
        end
    end

    // ---------------- stage 4: acc*dt^2/2
    logic   r_v4;
    t_carry r_c4;
    logic [2:0][31:0] r_pos4;
    logic [63:0] r_x4;
    logic signed [56:0] r_vdt4 [3];
    logic signed [56:0] r_ahd4 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (en)  r_v4 <= r_v3;
        if (en) begin
            r_c4   <= r_c3;
            r_pos4 <= r_pos3;
            r_x4   <= r_x3;
            for (int i = 0; i < 3; i++) begin
                r_vdt4[i] <= r_vdt3[i];
                r_ahd4[i] <= $signed(r_c3.acc[i]) * $signed({1'b0, r_hd2});
            end
        end
    end

    // ---------------- stage 5: new position, round half up, saturate
    logic   r_sv   [NSQ+1];
    t_carry r_sc   [NSQ+1];
    logic [63:0] r_sx   [NSQ+1];
    logic [35:0] r_srem [NSQ+1];
    logic [31:0] r_sroot[NSQ+1];
    t_carry n_c5;
    always_comb begin
        logic signed [63:0] sp;
        n_c5 = r_c4;
        for (int i = 0; i < 3; i++) begin
            sp = (64'($signed(r_pos4[i])) <<< 24) + 64'(r_vdt4[i]) + 64'(r_ahd4[i])
                 + 64'sd8388608;
            n_c5.npos[i] = sat32(sp >>> 24);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (en)  r_sv[0] <= r_v4;
        if (en) begin
            r_sc[0]    <= n_c5;
            r_sx[0]    <= r_x4;
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
        end
    end

    // ---------------- square root, one root bit per stage
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        ge;
        assign rem_sh = {r_srem[k][33:0], r_sx[k][63:62]};
        assign trial  = {2'b00, r_sroot[k], 2'b01};
        assign ge     = rem_sh >= trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else if (en)  r_sv[k+1] <= r_sv[k];
            if (en) begin
                r_sc[k+1]    <= r_sc[k];
                r_sx[k+1]    <= {r_sx[k][61:0], 2'b00};
                r_srem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                r_sroot[k+1] <= {r_sroot[k][30:0], ge};
            end
        end
    end

    // ---------------- stage 6: |v_i| * |v|
    logic   r_v6;
    t_carry r_c6;
    logic [39:0] r_p6 [3];
    always_ff @(posedge i_clk) begin
        logic [63:0] pr;
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (en)  r_v6 <= r_sv[NSQ];
        if (en) begin
            r_c6 <= r_sc[NSQ];
            for (int i = 0; i < 3; i++) begin
                pr = r_sc[NSQ].absv[i] * r_sroot[NSQ];
                r_p6[i] <= pr[63:24];
            end
        end
    end

    // ---------------- stage 7: drag factor partial products
    logic   r_v7;
    t_carry r_c7;
    logic [46:0] r_dh7 [3];
    logic [54:0] r_dl7 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (en)  r_v7 <= r_v6;
        if (en) begin
            r_c7 <= r_c6;
            for (int i = 0; i < 3; i++) begin
                r_dh7[i] <= r_drag_k * r_p6[i][39:24];
                r_dl7[i] <= r_drag_k * r_p6[i][23:0];
            end
        end
    end

    // ---------------- stage 8: drag magnitude
    logic   r_v8;
    t_carry r_c8;
    logic [47:0] r_drag8 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v8 <= 1'b0;
        else if (en)  r_v8 <= r_v7;
        if (en) begin
            r_c8 <= r_c7;
            for (int i = 0; i < 3; i++)
                r_drag8[i] <= 48'(r_dh7[i]) + 48'(r_dl7[i][54:24]);
        end
    end

    // ---------------- stage 9: new acceleration, drag opposes velocity
    logic   r_v9;
    t_carry r_c9;
    t_carry n_c9;
    always_comb begin
        logic signed [63:0] g;
        logic signed [63:0] d;
        n_c9 = r_c8;
        for (int i = 0; i < 3; i++) begin
            g = 64'(r_grav[i]);
            d = $signed({16'd0, r_drag8[i]});
            if (r_c8.vel[i][31])            g = g + d;
            else if (r_c8.vel[i] != '0)     g = g - d;
            n_c9.nacc[i] = sat32(g);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v9 <= 1'b0;
        else if (en)  r_v9 <= r_v8;
        if (en) r_c9 <= n_c9;
    end

    // ---------------- stage 10: acc + new_acc
    logic   r_v10;
    t_carry r_c10;
    logic signed [32:0] r_s10 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v10 <= 1'b0;
        else if (en)  r_v10 <= r_v9;
        if (en) begin
            r_c10 <= r_c9;
            for (int i = 0; i < 3; i++)
                r_s10[i] <= 33'($signed(r_c9.acc[i])) + 33'($signed(r_c9.nacc[i]));
        end
    end

    // ---------------- stage 11: (acc + new_acc) * dt
    logic   r_v11;
    t_carry r_c11;
    logic signed [57:0] r_sd11 [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v11 <= 1'b0;
        else if (en)  r_v11 <= r_v10;
        if (en) begin
            r_c11 <= r_c10;
            for (int i = 0; i < 3; i++)
                r_sd11[i] <= r_s10[i] * $signed({1'b0, r_c10.dt});
        end
    end

    // ---------------- stage 12: new velocity
    logic         r_v12;
    logic [287:0] r_d12;
    logic [287:0] n_d12;
    always_comb begin
        logic signed [63:0] sv;
        for (int i = 0; i < 3; i++) begin
            sv = (64'($signed(r_c11.vel[i])) <<< 25) + 64'(r_sd11[i]) + 64'sd16777216;
            n_d12[32*i +: 32]     = r_c11.npos[i];
            n_d12[32*(3+i) +: 32] = sat32(sv >>> 25);
            n_d12[32*(6+i) +: 32] = r_c11.nacc[i];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v12 <= 1'b0;
        else if (en)  r_v12 <= r_v11;
        if (en) r_d12 <= n_d12;
    end

    // ---------------- output register with skid
    logic         r_out_valid;
    logic [287:0] r_out;
    logic [287:0] r_skid;
    logic         last_xfer;
    assign last_xfer = en && r_v12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= last_xfer;
            end
        end else if (last_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : r_d12;
        end else if (last_xfer) begin
            r_skid <= r_d12;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output register empty");

    a_skid_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !o_s_tready)
        else $error("input taken while skid full");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && r_v12 && !r_skid_valid) |=> r_skid_valid)
        else $error("stalled result not caught by skid");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule
